// ===== hdl/tpsg_pkg.sv =====
package tpsg_pkg;

	// Width of the elapsed counter and of the stored durations.
	localparam int TimeBits = 32;
	// Logical level of the output after reset.
	localparam logic InitialOn = 1'b0;
	// Width of the duration fields of an input item.
	localparam int FieldBits = 32;

	typedef logic [TimeBits-1:0] time_t;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_ON        = 3'd1,
		CMD_OFF       = 3'd2,
		CMD_TIMED_ON  = 3'd3,
		CMD_TIMED_OFF = 3'd4,
		CMD_ON_OFF    = 3'd5,
		CMD_SQUARE    = 3'd6,
		CMD_INVERT    = 3'd7
	} cmd_e;

	typedef enum logic [2:0] {
		ACT_IDLE   = 3'd0,
		ACT_OFF    = 3'd1,
		ACT_ON     = 3'd2,
		ACT_ONOFF  = 3'd3,
		ACT_SQUARE = 3'd4
	} action_e;

	typedef struct packed {
		cmd_e                 cmd;
		logic [FieldBits-1:0] on_time;
		logic [FieldBits-1:0] off_time;
	} item_t;

	typedef struct packed {
		logic pin_level;
		logic is_on;
		logic done_res;
	} result_t;

	// Fits a duration field to the counter width, zero extending or truncating.
	function automatic time_t to_time(input logic [FieldBits-1:0] v);
		logic [127:0] wide;
		begin
			wide = 128'(v);
			return wide[TimeBits-1:0];
		end
	endfunction

endpackage

// ===== hdl/tpsg_if.sv =====
interface tpsg_in_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     cmd;
	logic [tpsg_pkg::FieldBits-1:0] on_time;
	logic [tpsg_pkg::FieldBits-1:0] off_time;

	modport source (output valid, output cmd, output on_time, output off_time, input ready);
	modport sink (input valid, input cmd, input on_time, input off_time, output ready);
endinterface

interface tpsg_out_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic is_on;
	logic done_res;

	modport source (output valid, output pin_level, output is_on, output done_res, input ready);
	modport sink (input valid, input pin_level, input is_on, input done_res, output ready);
endinterface

// ===== hdl/timed_output_pulse_square_generator_top.sv =====
// Throughput: one item per cycle while out_ch is not stalled. The state update for an item is a
// single pass from the input register through the timer compare and increment into the state
// and result registers; the result waits in the result register until out_ch takes it.
// Reset: arst_n is asynchronous and active low; it clears both pipeline valids, sets the
// output off (logically), clears the timers and pending action, and sets active_low to zero.
module timed_output_pulse_square_generator_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              active_low_we,
	input  logic              active_low_wdata,
	tpsg_in_if.sink           in_ch,
	tpsg_out_if.source        out_ch
);
	import tpsg_pkg::*;

	// Polarity register. The user must write it only while no item is in flight, so the result
	// of each item sees the value that was current when it was taken; the block does not enforce it.
	logic active_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= 1'b0;
		end else if (active_low_we) begin
			active_low_q <= active_low_wdata;
		end
	end

	// Input register. An item waits here until the result register can take its result.
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;

	// Result register. It parts the output handshake from the input side, so a new
	// item can be taken into an empty input register while a finished result waits to be collected.
	logic    out_valid_q;
	result_t res_q;
	result_t res_next;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.cmd      <= cmd_e'(in_ch.cmd);
			item_s1.on_time  <= in_ch.on_time;
			item_s1.off_time <= in_ch.off_time;
		end
	end

	// The timer and level state advance exactly once for each item that moves
	// from the input register into the result register.
	tpsg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.item       (item_s1),
		.active_low (active_low_q),
		.res        (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.pin_level = res_q.pin_level;
	assign out_ch.is_on     = res_q.is_on;
	assign out_ch.done_res  = res_q.done_res;

`ifndef NO_ASSERTIONS
	// A new result only appears when an item has moved out of the input register.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(advance))
		else $error("result appeared without an item");

	// A plain on command leaves the output on with nothing pending.
	a_plain_on: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_ON) |=> (out_ch.is_on && out_ch.done_res))
		else $error("plain on command gave a wrong result");

	// A timed on command turns the output on and leaves a switch-off pending.
	a_timed_on: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd == CMD_TIMED_ON) |=> (out_ch.is_on && !out_ch.done_res))
		else $error("timed on command gave a wrong result");
`endif

endmodule

// ===== hdl/tpsg_core.sv =====
module tpsg_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  tpsg_pkg::item_t   item,
	input  logic              active_low,
	output tpsg_pkg::result_t res
);
	import tpsg_pkg::*;

	logic    level_on_q;
	action_e act_q;
	time_t   elapsed_q;
	time_t   duration_q;
	time_t   saved_on_q;
	time_t   saved_off_q;

	logic    level_on_d;
	action_e act_d;
	time_t   elapsed_d;
	time_t   duration_d;
	time_t   saved_on_d;
	time_t   saved_off_d;

	time_t   elapsed_inc;
	logic    fire;
	logic    idle_now;

	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + time_t'(1) : elapsed_q;
	assign fire        = (elapsed_inc >= duration_q);
	assign idle_now    = (act_q == ACT_IDLE);

	always_comb begin
		level_on_d  = level_on_q;
		act_d       = act_q;
		elapsed_d   = elapsed_q;
		duration_d  = duration_q;
		saved_on_d  = saved_on_q;
		saved_off_d = saved_off_q;
		unique case (item.cmd)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (fire) begin
					unique case (act_q)
						ACT_OFF: begin
							level_on_d = 1'b0;
							act_d      = ACT_IDLE;
						end
						ACT_ON: begin
							level_on_d = 1'b1;
							act_d      = ACT_IDLE;
						end
						ACT_ONOFF: begin
							level_on_d = 1'b0;
							duration_d = saved_off_q;
							elapsed_d  = '0;
							act_d      = ACT_OFF;
						end
						ACT_SQUARE: begin
							level_on_d = ~level_on_q;
							duration_d = level_on_q ? saved_off_q : saved_on_q;
							elapsed_d  = '0;
						end
						default: begin
						end
					endcase
				end
			end
			CMD_ON, CMD_OFF: begin
				level_on_d = (item.cmd == CMD_ON);
				act_d      = ACT_IDLE;
			end
			CMD_TIMED_ON: begin
				level_on_d = 1'b1;
				duration_d = to_time(item.on_time);
				elapsed_d  = '0;
				act_d      = ACT_OFF;
			end
			CMD_TIMED_OFF: begin
				level_on_d = 1'b0;
				duration_d = to_time(item.off_time);
				elapsed_d  = '0;
				act_d      = ACT_ON;
			end
			CMD_ON_OFF: begin
				// Only taken when nothing is pending.
				if (idle_now) begin
					saved_on_d  = to_time(item.on_time);
					saved_off_d = to_time(item.off_time);
					level_on_d  = 1'b1;
					duration_d  = to_time(item.on_time);
					elapsed_d   = '0;
					act_d       = ACT_ONOFF;
				end
			end
			CMD_SQUARE: begin
				saved_on_d  = to_time(item.on_time);
				saved_off_d = to_time(item.off_time);
				level_on_d  = 1'b1;
				duration_d  = to_time(item.on_time);
				elapsed_d   = '0;
				act_d       = ACT_SQUARE;
			end
			CMD_INVERT: begin
				level_on_d = ~level_on_q;
				act_d      = ACT_IDLE;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.is_on     = level_on_d;
		res.pin_level = level_on_d ^ active_low;
		res.done_res  = (act_d == ACT_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_on_q  <= InitialOn;
			act_q       <= ACT_IDLE;
			elapsed_q   <= '0;
			duration_q  <= '0;
			saved_on_q  <= '0;
			saved_off_q <= '0;
		end else if (en) begin
			level_on_q  <= level_on_d;
			act_q       <= act_d;
			elapsed_q   <= elapsed_d;
			duration_q  <= duration_d;
			saved_on_q  <= saved_on_d;
			saved_off_q <= saved_off_d;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the timed pulse and square-wave generator.
//
// A driver and a monitor, both clocked always blocks, sit on the two channels. The driver
// takes items from cmd_queue, which the initial block below fills phase by phase. Every item
// that is accepted is run through a software copy of the generator. That copy yields the
// result the block must report, and the result goes to pin_forecast_q. The monitor compares
// every accepted result, field by field, with the oldest entry of that queue.
//
// The run has a short directed part, then four random phases. Each phase has its own setting
// of the polarity register and its own amount of sender idling and receiver stalling. The
// polarity register is only written once every expected result has come back.
module tb_top;

	import tpsg_pkg::*;

	// Cycle budget for the whole run. A correct run needs a small fraction of this.
	localparam int CycleLimit = 200000;
	// Cycles to wait after the last expected result, well past the two-stage pipeline.
	localparam int DrainCycles = 8;
	// Mismatch lines printed at most, so that a broken block does not flood the log.
	localparam int ReportCap = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic active_low_we;
	logic active_low_wdata;

	tpsg_in_if  in_ch ();
	tpsg_out_if out_ch ();

	timed_output_pulse_square_generator_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.active_low_we    (active_low_we),
		.active_low_wdata (active_low_wdata),
		.in_ch            (in_ch),
		.out_ch           (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items still to be offered, and results still to come back.
	item_t   cmd_queue[$];
	result_t pin_forecast_q[$];
	// The item that the driver is offering right now.
	item_t   held_item;

	// Percent chance, per cycle, that the sender idles or the receiver stalls.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatch_count = 0;
	int cycle_count    = 0;

	// Software copy of the generator state.
	logic    pol_low;
	logic    lvl_on;
	action_e pend_act;
	time_t   elapsed;
	time_t   duration;
	time_t   keep_on;
	time_t   keep_off;

	// Arms the timer. Starting any timed action restarts the elapsed count.
	function automatic void arm_timer(input time_t span, input action_e act);
		duration = span;
		elapsed  = '0;
		pend_act = act;
	endfunction

	// One millisecond tick. The elapsed count saturates at all ones, and it keeps counting
	// while nothing is pending. The pending action fires once the count reaches the duration,
	// so a duration of zero fires on the very next tick.
	function automatic void advance_tick();
		if (elapsed != '1)
			elapsed = elapsed + 1'b1;
		if (elapsed >= duration) begin
			case (pend_act)
				ACT_OFF: begin
					lvl_on   = 1'b0;
					pend_act = ACT_IDLE;
				end
				ACT_ON: begin
					lvl_on   = 1'b1;
					pend_act = ACT_IDLE;
				end
				ACT_ONOFF: begin
					lvl_on = 1'b0;
					arm_timer(keep_off, ACT_OFF);
				end
				ACT_SQUARE: begin
					if (lvl_on) begin
						lvl_on = 1'b0;
						arm_timer(keep_off, ACT_SQUARE);
					end else begin
						lvl_on = 1'b1;
						arm_timer(keep_on, ACT_SQUARE);
					end
				end
				default: ;
			endcase
		end
	endfunction

	// Applies one item to the software copy and returns the result that it must produce.
	function automatic result_t apply_command(input item_t it);
		result_t r;
		case (it.cmd)
			CMD_TICK: advance_tick();
			CMD_ON: begin
				lvl_on   = 1'b1;
				pend_act = ACT_IDLE;
			end
			CMD_OFF: begin
				lvl_on   = 1'b0;
				pend_act = ACT_IDLE;
			end
			CMD_TIMED_ON: begin
				lvl_on = 1'b1;
				arm_timer(time_t'(it.on_time), ACT_OFF);
			end
			CMD_TIMED_OFF: begin
				lvl_on = 1'b0;
				arm_timer(time_t'(it.off_time), ACT_ON);
			end
			CMD_ON_OFF: begin
				// The one-shot pulse is only taken when nothing else is pending.
				if (pend_act == ACT_IDLE) begin
					keep_on  = time_t'(it.on_time);
					keep_off = time_t'(it.off_time);
					lvl_on   = 1'b1;
					arm_timer(time_t'(it.on_time), ACT_ONOFF);
				end
			end
			CMD_SQUARE: begin
				keep_on  = time_t'(it.on_time);
				keep_off = time_t'(it.off_time);
				lvl_on   = 1'b1;
				arm_timer(time_t'(it.on_time), ACT_SQUARE);
			end
			default: begin
				lvl_on   = ~lvl_on;
				pend_act = ACT_IDLE;
			end
		endcase
		r.pin_level = lvl_on ^ pol_low;
		r.is_on     = lvl_on;
		r.done_res  = (pend_act == ACT_IDLE);
		return r;
	endfunction

	// Driver. An item counts as taken at an edge where valid and ready were both high; only
	// then, or while nothing is offered, may a new item be put on the channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				pin_forecast_q.push_back(apply_command(held_item));
			if (!in_ch.valid || in_ch.ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_item = cmd_queue.pop_front();
					in_ch.valid    <= 1'b1;
					in_ch.cmd      <= held_item.cmd;
					in_ch.on_time  <= held_item.on_time;
					in_ch.off_time <= held_item.off_time;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Results are checked at the edge where they are taken, and ready is redrawn
	// every cycle so that stalls fall on any phase of the block's work.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pin_forecast_q.size() == 0) begin
					if (mismatch_count < ReportCap)
						$display("%0t: unexpected result pin=%b on=%b done=%b", $time,
							out_ch.pin_level, out_ch.is_on, out_ch.done_res);
					mismatch_count++;
				end else begin
					result_t want;
					want = pin_forecast_q.pop_front();
					if (out_ch.pin_level !== want.pin_level || out_ch.is_on !== want.is_on ||
					    out_ch.done_res !== want.done_res) begin
						if (mismatch_count < ReportCap)
							$display("%0t: expected pin=%b on=%b done=%b, got pin=%b on=%b done=%b",
								$time, want.pin_level, want.is_on, want.done_res,
								out_ch.pin_level, out_ch.is_on, out_ch.done_res);
						mismatch_count++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a hung block ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timed_output_pulse_square_generator_top verification failed");
			$finish;
		end
	end

	function automatic logic [FieldBits-1:0] wide_value();
		case ($urandom_range(3))
			0: return '1;
			1: return {1'b1, (FieldBits-1)'($urandom)};
			default: return FieldBits'($urandom);
		endcase
	endfunction

	// Short durations, so that ticks actually reach them; zero is drawn now and then.
	function automatic logic [FieldBits-1:0] short_span();
		if ($urandom_range(99) < 15)
			return '0;
		return FieldBits'($urandom_range(1, 6));
	endfunction

	task automatic push_item(input cmd_e c, input logic [FieldBits-1:0] a,
	                         input logic [FieldBits-1:0] b);
		item_t it;
		it.cmd      = c;
		it.on_time  = a;
		it.off_time = b;
		cmd_queue.push_back(it);
	endtask

	task automatic push_ticks(input int n);
		for (int k = 0; k < n; k++)
			push_item(CMD_TICK, wide_value(), wide_value());
	endtask

	// Random stimulus. Most of it is a timed command with short durations followed by a run
	// of ticks, so that actions fire, square waves toggle and one-shot pulses finish. The rest
	// is plain commands, timed commands with wide durations, and one-shot pulses that arrive
	// while something is still pending.
	task automatic queue_random_items(input int count);
		int made;
		int pick;
		int run;
		cmd_e c;
		logic [FieldBits-1:0] a;
		logic [FieldBits-1:0] b;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				c = cmd_e'($urandom_range(CMD_TIMED_ON, CMD_SQUARE));
				a = short_span();
				b = short_span();
				// The field that a command does not use gets any value at all.
				if (c == CMD_TIMED_ON)
					b = wide_value();
				if (c == CMD_TIMED_OFF)
					a = wide_value();
				push_item(c, a, b);
				run = $urandom_range(20);
				for (int k = 0; k < run; k++) begin
					if ($urandom_range(99) < 6)
						push_item(cmd_e'($urandom_range(7)), short_span(), wide_value());
					else
						push_ticks(1);
				end
				made += 1 + run;
			end else if (pick < 85) begin
				case ($urandom_range(2))
					0: c = CMD_ON;
					1: c = CMD_OFF;
					default: c = CMD_INVERT;
				endcase
				push_item(c, wide_value(), wide_value());
				made += 1;
			end else if (pick < 93) begin
				push_item(cmd_e'($urandom_range(CMD_TIMED_ON, CMD_SQUARE)),
					wide_value(), wide_value());
				run = $urandom_range(3);
				push_ticks(run);
				made += 1 + run;
			end else begin
				push_item(CMD_ON_OFF, short_span(), short_span());
				push_item(CMD_ON_OFF, wide_value(), wide_value());
				run = $urandom_range(10);
				push_ticks(run);
				made += 2 + run;
			end
		end
	endtask

	// Waits at falling edges until every item has been taken and every result checked.
	task automatic wait_drained();
		while (cmd_queue.size() != 0 || in_ch.valid || pin_forecast_q.size() != 0)
			@(negedge clk);
	endtask

	// Writes the polarity register while the pipeline is empty.
	task automatic write_polarity(input logic v);
		@(posedge clk);
		active_low_we    <= 1'b1;
		active_low_wdata <= v;
		pol_low = v;
		@(posedge clk);
		active_low_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic pol, input int idle_pct, input int stall_pct,
	                         input int count);
		wait_drained();
		write_polarity(pol);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random_items(count);
	endtask

	initial begin
		arst_n           = 1'b0;
		active_low_we    = 1'b0;
		active_low_wdata = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.cmd        = CMD_TICK;
		in_ch.on_time    = '0;
		in_ch.off_time   = '0;
		out_ch.ready     = 1'b0;

		// The software copy starts where reset leaves the block.
		pol_low  = 1'b0;
		lvl_on   = InitialOn;
		pend_act = ACT_IDLE;
		elapsed  = '0;
		duration = '0;
		keep_on  = '0;
		keep_off = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with no idling on either side.
		write_polarity(1'b0);
		push_item(CMD_TICK, '0, '0);
		push_item(CMD_ON, '1, '1);
		push_item(CMD_OFF, '0, '1);
		push_item(CMD_INVERT, '1, '0);
		push_item(CMD_INVERT, '0, '0);
		// A zero duration fires on the very next tick.
		push_item(CMD_TIMED_ON, '0, '1);
		push_item(CMD_TICK, '1, '1);
		push_item(CMD_TIMED_OFF, '1, 2);
		push_ticks(2);
		// A one-shot pulse, then a second one while the first is pending, which is ignored.
		push_item(CMD_ON_OFF, 1, 1);
		push_item(CMD_ON_OFF, 0, 0);
		push_ticks(2);
		push_item(CMD_SQUARE, 1, 2);
		push_ticks(3);
		// A plain command cancels the running square wave.
		push_item(CMD_ON, 0, 0);
		push_item(CMD_SQUARE, 0, 0);
		push_ticks(2);
		// The widest duration never fires in this run; a timed command replaces it.
		push_item(CMD_TIMED_ON, '1, '0);
		push_item(CMD_TICK, 0, 0);
		push_item(CMD_TIMED_OFF, '0, '1);
		push_item(CMD_SQUARE, 2, 3);

		// The square wave from the directed part is still running across this write: the
		// polarity changes only the pin, and the logical state carries on.
		run_phase(1'b1, 0, 0, 450);
		run_phase(1'b0, 78, 0, 450);
		run_phase(1'b1, 0, 78, 450);
		run_phase(1'b0, 14, 14, 450);

		wait_drained();
		repeat (DrainCycles) @(negedge clk);

		if (mismatch_count == 0 && pin_forecast_q.size() == 0)
			$display("timed_output_pulse_square_generator_top verification clean");
		else
			$display("timed_output_pulse_square_generator_top verification failed");
		$finish;
	end

endmodule
